// ===== sv/line_substring_filter_macros.svh =====
// assertion macros used by the checker file
`ifndef LINE_SUBSTRING_FILTER_MACROS_SVH
`define LINE_SUBSTRING_FILTER_MACROS_SVH

// same-cycle implication, disabled during reset
`define LSF_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("line_substring_filter check failed");

// next-cycle implication, disabled during reset
`define LSF_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("line_substring_filter check failed");

`endif

// ===== sv/lsf_pkg.sv =====
// shared types and constants of the line substring filter
package lsf_pkg;

  localparam logic [7:0] NEWLINE_BYTE = 8'd10;
  localparam logic [7:0] LEN_MAX      = 8'd255;

  // configuration register indexes
  localparam logic [2:0] CFG_PAT_0   = 3'd0;
  localparam logic [2:0] CFG_PAT_1   = 3'd1;
  localparam logic [2:0] CFG_PAT_2   = 3'd2;
  localparam logic [2:0] CFG_PAT_3   = 3'd3;
  localparam logic [2:0] CFG_PAT_LEN = 3'd4;

  // one finished line report
  typedef struct packed {
    logic       matched;
    logic [7:0] line_length;
    logic       search_done;
  } res_t;

endpackage

// ===== sv/lsf_match.sv =====
// shift-and step: compares one text byte against all pattern bytes
module lsf_match #(
  parameter int MAX_PATTERN = 32
) (
  input  logic [MAX_PATTERN*8-1:0] pat_bytes,
  input  logic [5:0]               act_len,
  input  logic [7:0]               text_byte,
  input  logic [MAX_PATTERN-1:0]   mask,
  output logic [MAX_PATTERN-1:0]   mask_next,
  output logic                     hit
);

  logic [MAX_PATTERN-1:0] eq;
  logic [MAX_PATTERN-1:0] last_bit;

  always_comb begin
    for (int i = 0; i < MAX_PATTERN; i++) begin
      eq[i]       = (pat_bytes[8*i +: 8] == text_byte) && (6'(i) < act_len);
      last_bit[i] = (6'(i + 1) == act_len);
    end
  end

  assign mask_next = ((mask << 1) | MAX_PATTERN'(1)) & eq;
  assign hit       = |(mask_next & last_bit);

endmodule

// ===== sv/lsf_line.sv =====
// input register, per-line search state and result register
module lsf_line #(
  parameter int MAX_PATTERN   = 32,
  parameter int LINE_CAPACITY = 256
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic [MAX_PATTERN*8-1:0] pat_bytes,
  input  logic [5:0]               act_len,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [7:0]               in_byte,
  input  logic                     in_last,
  output logic                     out_valid,
  input  logic                     out_ready,
  output lsf_pkg::res_t            out_res
);

  localparam int CNT_W = (LINE_CAPACITY > 2) ? $clog2(LINE_CAPACITY) : 1;
  localparam logic [CNT_W-1:0] CAP_LAST = CNT_W'(LINE_CAPACITY - 1);

  logic                   hold_valid;
  logic                   hold_valid_next;
  logic [7:0]             hold_byte;
  logic                   hold_last;
  logic                   adv;
  logic                   proc;

  logic [MAX_PATTERN-1:0] mask;
  logic [MAX_PATTERN-1:0] mask_next;
  logic [MAX_PATTERN-1:0] step_mask;
  logic                   step_hit;
  logic                   found;
  logic                   found_next;
  logic [CNT_W-1:0]       count;
  logic [CNT_W-1:0]       count_next;
  logic                   halted;
  logic                   halted_next;
  logic                   emit;
  logic                   emit_done;
  logic [CNT_W+8:0]       count_ext;
  logic [7:0]             len_sat;
  logic                   res_valid;
  logic                   res_valid_next;
  lsf_pkg::res_t          res;

  lsf_match #(.MAX_PATTERN(MAX_PATTERN)) u_match (
    .pat_bytes (pat_bytes),
    .act_len   (act_len),
    .text_byte (hold_byte),
    .mask      (mask),
    .mask_next (step_mask),
    .hit       (step_hit)
  );

  assign adv      = !res_valid || out_ready;
  assign in_ready = !hold_valid || adv;
  assign proc     = hold_valid && adv;

  assign count_ext = {9'b0, count};
  assign len_sat   = (count_ext > (CNT_W+9)'(lsf_pkg::LEN_MAX)) ? lsf_pkg::LEN_MAX
                                                                : count_ext[7:0];

  always_comb begin
    hold_valid_next = hold_valid;
    if (in_valid && in_ready) begin
      hold_valid_next = 1'b1;
    end else if (adv) begin
      hold_valid_next = 1'b0;
    end
  end

  always_comb begin
    emit       = 1'b0;
    emit_done  = 1'b0;
    mask_next  = mask;
    found_next = found;
    count_next = count;
    if (proc && !halted) begin
      priority if (hold_last) begin
        emit      = 1'b1;
        emit_done = 1'b1;
      end else if (hold_byte == lsf_pkg::NEWLINE_BYTE) begin
        emit      = 1'b1;
        emit_done = (count == '0);
      end else if (count == CAP_LAST) begin
        emit      = 1'b1;
      end else begin
        mask_next  = step_mask;
        found_next = found || step_hit;
        count_next = count + CNT_W'(1);
      end
      if (emit) begin
        mask_next  = '0;
        found_next = 1'b0;
        count_next = '0;
      end
    end
    halted_next = halted || emit_done;
  end

  always_comb begin
    res_valid_next = res_valid;
    if (emit) begin
      res_valid_next = 1'b1;
    end else if (out_ready) begin
      res_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
      mask       <= '0;
      found      <= 1'b0;
      count      <= '0;
      halted     <= 1'b0;
      res_valid  <= 1'b0;
    end else begin
      hold_valid <= hold_valid_next;
      mask       <= mask_next;
      found      <= found_next;
      count      <= count_next;
      halted     <= halted_next;
      res_valid  <= res_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      hold_byte <= in_byte;
      hold_last <= in_last;
    end
    if (emit) begin
      res.matched     <= found;
      res.line_length <= len_sat;
      res.search_done <= emit_done;
    end
  end

  assign out_valid = res_valid;
  assign out_res   = res;

endmodule

// ===== sv/line_substring_filter.sv =====
// top level of the line substring filter
// Reports, for every line of a text byte stream, whether it holds the configured
// fixed pattern. One byte request is taken per clock cycle unless m_tready holds
// back a pending report. The byte that ends a line (newline, end of input on tlast,
// or the byte that overflows a full line) goes to the input register, then its
// report to the result register. The rate is set by the shift-and update of the
// prefix mask, which compares the byte against every pattern byte in parallel. An
// empty line or end of input ends the search; later requests are taken and dropped
// until reset. The user writes pattern registers while the stream is idle (not enforced).
module line_substring_filter #(
  parameter int MAX_PATTERN   = 32,
  parameter int LINE_CAPACITY = 256
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [63:0] cfg_data,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // text_byte
  input  logic        s_tlast,   // end_of_input
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,   // line_length
  output logic        m_tuser,   // matched
  output logic        m_tlast    // search_done
);

  logic [63:0]    pat_reg [4];
  logic [255:0]   pat_flat;
  logic [5:0]     pat_len;
  logic [5:0]     act_len;
  lsf_pkg::res_t  res;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      pat_reg[0] <= '0;
      pat_reg[1] <= '0;
      pat_reg[2] <= '0;
      pat_reg[3] <= '0;
      pat_len    <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        lsf_pkg::CFG_PAT_0:   pat_reg[0] <= cfg_data;
        lsf_pkg::CFG_PAT_1:   pat_reg[1] <= cfg_data;
        lsf_pkg::CFG_PAT_2:   pat_reg[2] <= cfg_data;
        lsf_pkg::CFG_PAT_3:   pat_reg[3] <= cfg_data;
        lsf_pkg::CFG_PAT_LEN: pat_len    <= cfg_data[5:0];
        default: ;
      endcase
    end
  end

  assign pat_flat = {pat_reg[3], pat_reg[2], pat_reg[1], pat_reg[0]};
  assign act_len  = (pat_len > 6'(MAX_PATTERN)) ? 6'(MAX_PATTERN) : pat_len;

  lsf_line #(
    .MAX_PATTERN   (MAX_PATTERN),
    .LINE_CAPACITY (LINE_CAPACITY)
  ) u_line (
    .clk       (clk),
    .rst       (rst),
    .pat_bytes (pat_flat[MAX_PATTERN*8-1:0]),
    .act_len   (act_len),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .in_byte   (s_tdata),
    .in_last   (s_tlast),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_res   (res)
  );

  assign m_tdata = res.line_length;
  assign m_tuser = res.matched;
  assign m_tlast = res.search_done;

endmodule

// ===== sv/lsf_checker.sv =====
// port-level checks of the line substring filter and their binding
`include "line_substring_filter_macros.svh"

module lsf_checker (
  input logic       clk,
  input logic       rst,
  input logic       m_tvalid,
  input logic       m_tready,
  input logic [7:0] m_tdata,
  input logic       m_tuser,
  input logic       m_tlast
);

  `LSF_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast))
  `LSF_ASSERT_NEXT(a_quiet_after_done, m_tvalid && m_tready && m_tlast, !m_tvalid)
  `LSF_ASSERT_NOW(a_empty_ends_search, m_tvalid && (m_tdata == 8'd0), m_tlast)
  `LSF_ASSERT_NOW(a_match_needs_bytes, m_tvalid && m_tuser, m_tdata != 8'd0)

endmodule

bind line_substring_filter lsf_checker u_lsf_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser),
  .m_tlast  (m_tlast)
);
